FILE: hw/rtl/byte_coded_register_cpu_step_assert.svh
// Assertion macros for the byte-coded register machine step block.
// Used by the top level only; no other dependencies.
`ifndef BYTE_CODED_REGISTER_CPU_STEP_ASSERT_SVH
`define BYTE_CODED_REGISTER_CPU_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define BCR_ASSERT_IMPL(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("bcr implication check failed");
`define BCR_ASSERT_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("bcr next-cycle check failed");
`else
`define BCR_ASSERT_IMPL(lbl, ck, rs, a, b)
`define BCR_ASSERT_NEXT(lbl, ck, rs, a, b)
`endif
`endif

FILE: hw/rtl/bcr_pkg.sv
// Package for the byte-coded register machine step block.
// Opcodes, widths and per-opcode decode functions; no dependencies.
package bcr_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int REG_COUNT     = 256;
  localparam int RIDX_W        = 8;
  localparam int ALU_W         = 34;

  localparam logic [7:0] OPC_LDI = 8'h00;
  localparam logic [7:0] OPC_MOV = 8'h01;
  localparam logic [7:0] OPC_LDB = 8'h02;
  localparam logic [7:0] OPC_LDH = 8'h03;
  localparam logic [7:0] OPC_LDW = 8'h04;
  localparam logic [7:0] OPC_STB = 8'h05;
  localparam logic [7:0] OPC_STH = 8'h06;
  localparam logic [7:0] OPC_STW = 8'h07;
  localparam logic [7:0] OPC_MUL = 8'h08;
  localparam logic [7:0] OPC_DIV = 8'h09;
  localparam logic [7:0] OPC_LDS = 8'h1E;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  // Operand bytes that follow the opcode.
  function automatic logic [2:0] opr_count(input logic [7:0] opc);
    case (opc)
      OPC_LDI: opr_count = 3'd5;
      OPC_MOV, OPC_LDB, OPC_LDH, OPC_LDW,
      OPC_STB, OPC_STH, OPC_STW, OPC_LDS: opr_count = 3'd2;
      OPC_MUL, OPC_DIV: opr_count = 3'd4;
      default: opr_count = 3'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_cost(input logic [7:0] opc);
    case (opc)
      OPC_LDI, OPC_LDH, OPC_STH: op_cost = 6'd6;
      OPC_MOV, OPC_LDS:          op_cost = 6'd3;
      OPC_LDB, OPC_STB, OPC_MUL: op_cost = 6'd5;
      OPC_LDW, OPC_STW:          op_cost = 6'd8;
      OPC_DIV:                   op_cost = 6'd38;
      default:                   op_cost = 6'd1;
    endcase
  endfunction

  // Bytes moved by a memory load or store.
  function automatic logic [2:0] acc_bytes(input logic [7:0] opc);
    case (opc)
      OPC_LDH, OPC_STH: acc_bytes = 3'd2;
      OPC_LDW, OPC_STW: acc_bytes = 3'd4;
      default:          acc_bytes = 3'd1;
    endcase
  endfunction

  function automatic logic wr_first(input logic [7:0] opc);
    case (opc)
      OPC_LDI, OPC_MOV, OPC_LDB, OPC_LDH, OPC_LDW,
      OPC_MUL, OPC_DIV, OPC_LDS: wr_first = 1'b1;
      default: wr_first = 1'b0;
    endcase
  endfunction

  function automatic logic wr_second(input logic [7:0] opc);
    case (opc)
      OPC_MUL, OPC_DIV: wr_second = 1'b1;
      default:          wr_second = 1'b0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/bcr_req_if.sv
// Request channel of the byte-coded register machine step block.
// Depends on nothing.
interface bcr_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] load_addr;
  logic [7:0]  load_data;
  modport source (output valid, op, load_addr, load_data, input ready);
  modport sink (input valid, op, load_addr, load_data, output ready);
endinterface

FILE: hw/rtl/bcr_rsp_if.sv
// Result channel of the byte-coded register machine step block.
// Depends on nothing.
interface bcr_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  executed_opcode;
  logic [5:0]  cycle_cost;
  logic [15:0] pc_after;
  logic        first_write_valid;
  logic [7:0]  first_write_index;
  logic [31:0] first_write_value;
  logic        second_write_valid;
  logic [7:0]  second_write_index;
  logic [31:0] second_write_value;
  modport source (output valid, executed_opcode, cycle_cost, pc_after, first_write_valid,
    first_write_index, first_write_value, second_write_valid, second_write_index,
    second_write_value, input ready);
  modport sink (input valid, executed_opcode, cycle_cost, pc_after, first_write_valid,
    first_write_index, first_write_value, second_write_valid, second_write_index,
    second_write_value, output ready);
endinterface

FILE: hw/rtl/bcr_alu.sv
// Shared add/subtract unit: address offsets and divide trial subtraction.
// Depends on bcr_pkg.
module bcr_alu (
  input  bcr_pkg::alu_ctl_t          ctl,
  input  logic [bcr_pkg::ALU_W-1:0]  a,
  input  logic [bcr_pkg::ALU_W-1:0]  b,
  output logic [bcr_pkg::ALU_W-1:0]  y
);
  assign y = ctl.sub ? (a - b) : (a + b);
endmodule

FILE: hw/rtl/byte_coded_register_cpu_step.sv
// Sequence: a byte-write request is reported in the cycle after it is taken; an instruction
//   fetches its opcode and operand bytes, decodes, reads registers if it uses them, then runs
//   S_LDI and S_LDC per loaded byte, S_ST per stored byte, S_MUL, or the divide steps for a
//   nonzero divisor, and S_WR1, S_WR2 when it writes registers. One request at a time.
// Reset: synchronous; a clearing pass writes zero to all MEM_BYTES memory bytes
//   before the first request is taken. Register valid bits clear at once.
`include "byte_coded_register_cpu_step_assert.svh"

module byte_coded_register_cpu_step #(
  parameter int MEM_BYTES = bcr_pkg::MEM_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  bcr_req_if.sink  req,
  bcr_rsp_if.source rsp
);
  localparam int AW = $clog2(MEM_BYTES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FCAP = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_RB   = 4'd4;
  localparam logic [3:0] S_RA   = 4'd5;
  localparam logic [3:0] S_RCAP = 4'd6;
  localparam logic [3:0] S_EXE  = 4'd7;
  localparam logic [3:0] S_LDI  = 4'd8;
  localparam logic [3:0] S_LDC  = 4'd9;
  localparam logic [3:0] S_ST   = 4'd10;
  localparam logic [3:0] S_MUL  = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_WR1  = 4'd13;
  localparam logic [3:0] S_WR2  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]    state;
  logic [AW-1:0] pc;
  logic [AW-1:0] clr_addr;
  logic [7:0]    opc;
  logic [7:0]    fb [1:5];
  logic [2:0]    nops;
  logic [2:0]    cnt;
  logic [4:0]    dcnt;
  logic [31:0]   rbv, rav, v1, v2;

  // result register
  logic        out_v;
  logic        out_set;
  logic [7:0]  r_opc;
  logic [5:0]  r_cost;
  logic [15:0] r_pc;
  logic        r_w1, r_w2;
  logic [7:0]  r_i1, r_i2;
  logic [31:0] r_v1, r_v2;

  // byte memory
  logic [7:0]    bmem [MEM_BYTES];
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_we;
  logic [7:0]    mem_wdata, mem_q;

  // register file, one valid bit per entry
  logic [31:0]                   rf_mem [bcr_pkg::REG_COUNT];
  logic [bcr_pkg::REG_COUNT-1:0] rf_vld;
  logic [bcr_pkg::RIDX_W-1:0]    rf_raddr, rf_waddr;
  logic                          rf_we;
  logic [31:0]                   rf_wdata, rf_q, rval;
  logic                          rf_qv;

  // shared add/subtract unit
  bcr_pkg::alu_ctl_t          alu_ctl;
  logic [bcr_pkg::ALU_W-1:0]  alu_a, alu_b, alu_y;
  logic                       is_store;
  logic [7:0]                 i1;
  logic [2:0]                 cur_n;
  logic                       req_fire;

  bcr_alu u_alu (.ctl(alu_ctl), .a(alu_a), .b(alu_b), .y(alu_y));

  assign req.ready = (state == S_IDLE) && (!out_v || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign is_store  = (opc == bcr_pkg::OPC_STB) || (opc == bcr_pkg::OPC_STH) ||
                     (opc == bcr_pkg::OPC_STW);
  assign i1        = ((opc == bcr_pkg::OPC_LDI) || (opc == bcr_pkg::OPC_LDS)) ? fb[1] : fb[2];
  assign rval      = rf_qv ? rf_q : 32'd0;
  assign cur_n     = (cnt == 3'd0) ? bcr_pkg::opr_count(mem_q) : nops;
  // load a new result: a byte write as it is taken, an instruction when it is done
  assign out_set   = ((state == S_IDLE) && req_fire && !req.op) ||
                     ((state == S_DONE) && (!out_v || rsp.ready));

  // Divide runs restoring steps through the unit; otherwise it forms base + byte offset.
  always_comb begin
    if (state == S_DIV) begin
      alu_ctl.sub = 1'b1;
      alu_a       = {1'b0, v2, v1[31]};
      alu_b       = {2'b00, rbv};
    end else begin
      alu_ctl.sub = 1'b0;
      alu_a       = {2'b00, (is_store ? rav : rbv)};
      alu_b       = {31'd0, cnt};
    end
  end

  always_comb begin
    mem_raddr = pc;
    if (state == S_LDI) mem_raddr = alu_y[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'd0;
    case (state)
      S_CLR: mem_we = 1'b1;
      S_IDLE: begin
        mem_we    = req_fire && !req.op;
        mem_waddr = req.load_addr[AW-1:0];
        mem_wdata = req.load_data;
      end
      S_ST: begin
        mem_we    = 1'b1;
        mem_waddr = alu_y[AW-1:0];
        mem_wdata = 8'(rbv >> {cnt[1:0], 3'b000});
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    rf_raddr = fb[1];
    if (state == S_RA) begin
      rf_raddr = ((opc == bcr_pkg::OPC_MUL) || (opc == bcr_pkg::OPC_DIV)) ? fb[3] : fb[2];
    end
    rf_we    = 1'b0;
    rf_waddr = i1;
    rf_wdata = v1;
    if (state == S_WR1) begin
      rf_we = bcr_pkg::wr_first(opc);
    end else if (state == S_WR2) begin
      rf_we    = bcr_pkg::wr_second(opc);
      rf_waddr = fb[4];
      rf_wdata = v2;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) bmem[mem_waddr] <= mem_wdata;
    mem_q <= bmem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_q <= rf_mem[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rf_qv  <= 1'b0;
    end else begin
      if (rf_we) rf_vld[rf_waddr] <= 1'b1;
      rf_qv <= rf_vld[rf_raddr];
    end
  end

  // Sequencer: fetch, read operands, run the operation, write back, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      pc       <= '0;
      out_v    <= 1'b0;
    end else begin
      if (out_set) out_v <= 1'b1;
      else if (rsp.valid && rsp.ready) out_v <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_fire) begin
            if (req.op) begin
              pc    <= pc + AW'(1);
              cnt   <= 3'd0;
              state <= S_FCAP;
            end else begin
              // byte write: report right away with the pc unchanged
              r_opc  <= 8'd0;
              r_cost <= 6'd0;
              r_pc   <= 16'(pc);
              r_w1   <= 1'b0;
              r_i1   <= 8'd0;
              r_v1   <= 32'd0;
              r_w2   <= 1'b0;
              r_i2   <= 8'd0;
              r_v2   <= 32'd0;
            end
          end
        end
        S_FCAP: begin
          if (cnt == 3'd0) begin
            opc  <= mem_q;
            nops <= cur_n;
          end else begin
            fb[cnt] <= mem_q;
          end
          if (cnt == cur_n) begin
            state <= S_DEC;
          end else begin
            pc  <= pc + AW'(1);
            cnt <= cnt + 3'd1;
          end
        end
        S_DEC: begin
          case (opc)
            bcr_pkg::OPC_LDI: begin
              v1    <= {fb[5], fb[4], fb[3], fb[2]};
              state <= S_WR1;
            end
            bcr_pkg::OPC_LDS: begin
              v1    <= {{24{fb[2][7]}}, fb[2]};
              state <= S_WR1;
            end
            bcr_pkg::OPC_MOV, bcr_pkg::OPC_LDB, bcr_pkg::OPC_LDH, bcr_pkg::OPC_LDW,
            bcr_pkg::OPC_STB, bcr_pkg::OPC_STH, bcr_pkg::OPC_STW,
            bcr_pkg::OPC_MUL, bcr_pkg::OPC_DIV: state <= S_RB;
            default: state <= S_DONE;
          endcase
        end
        S_RB: state <= S_RA;
        S_RA: begin
          rbv   <= rval;
          state <= S_RCAP;
        end
        S_RCAP: begin
          rav   <= rval;
          state <= S_EXE;
        end
        S_EXE: begin
          cnt <= 3'd0;
          case (opc)
            bcr_pkg::OPC_MOV: begin
              v1    <= rbv;
              state <= S_WR1;
            end
            bcr_pkg::OPC_LDB, bcr_pkg::OPC_LDH, bcr_pkg::OPC_LDW: begin
              v1    <= 32'd0;
              state <= S_LDI;
            end
            bcr_pkg::OPC_STB, bcr_pkg::OPC_STH, bcr_pkg::OPC_STW: state <= S_ST;
            bcr_pkg::OPC_MUL: state <= S_MUL;
            bcr_pkg::OPC_DIV: begin
              if (rbv == 32'd0) begin
                v1    <= 32'hFFFF_FFFF;
                v2    <= rav;
                state <= S_WR1;
              end else begin
                v1    <= rav;
                v2    <= 32'd0;
                dcnt  <= 5'd0;
                state <= S_DIV;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_LDI: state <= S_LDC;
        S_LDC: begin
          v1  <= v1 | (32'(mem_q) << {cnt[1:0], 3'b000});
          cnt <= cnt + 3'd1;
          if (3'(cnt + 3'd1) == bcr_pkg::acc_bytes(opc)) state <= S_WR1;
          else state <= S_LDI;
        end
        S_ST: begin
          cnt <= cnt + 3'd1;
          if (3'(cnt + 3'd1) == bcr_pkg::acc_bytes(opc)) state <= S_DONE;
        end
        S_MUL: begin
          {v2, v1} <= {32'd0, rav} * {32'd0, rbv};
          state    <= S_WR1;
        end
        S_DIV: begin
          // keep the difference when no borrow, else the shifted remainder
          if (!alu_y[bcr_pkg::ALU_W-1]) v2 <= alu_y[31:0];
          else v2 <= {v2[30:0], v1[31]};
          v1   <= {v1[30:0], !alu_y[bcr_pkg::ALU_W-1]};
          dcnt <= dcnt + 5'd1;
          if (&dcnt) state <= S_WR1;
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_DONE;
        S_DONE: begin
          if (!out_v || rsp.ready) begin
            r_opc  <= opc;
            r_cost <= bcr_pkg::op_cost(opc);
            r_pc   <= 16'(pc);
            r_w1   <= bcr_pkg::wr_first(opc);
            r_i1   <= bcr_pkg::wr_first(opc) ? i1 : 8'd0;
            r_v1   <= bcr_pkg::wr_first(opc) ? v1 : 32'd0;
            r_w2   <= bcr_pkg::wr_second(opc);
            r_i2   <= bcr_pkg::wr_second(opc) ? fb[4] : 8'd0;
            r_v2   <= bcr_pkg::wr_second(opc) ? v2 : 32'd0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid              = out_v;
  assign rsp.executed_opcode    = r_opc;
  assign rsp.cycle_cost         = r_cost;
  assign rsp.pc_after           = r_pc;
  assign rsp.first_write_valid  = r_w1;
  assign rsp.first_write_index  = r_i1;
  assign rsp.first_write_value  = r_v1;
  assign rsp.second_write_valid = r_w2;
  assign rsp.second_write_index = r_i2;
  assign rsp.second_write_value = r_v2;

  // no request is taken while the clearing pass runs
  `BCR_ASSERT_IMPL(a_no_req_in_clear, clk, rst, state == S_CLR, !req.ready)
  // a second write is only ever reported together with a first one
  `BCR_ASSERT_IMPL(a_second_has_first, clk, rst, out_v && r_w2, r_w1)
  // a taken instruction leaves idle for the fetch
  `BCR_ASSERT_NEXT(a_fetch_follows, clk, rst, req_fire && req.op, state == S_FCAP)

endmodule

FILE: bench/tb_byte_coded_register_cpu_step.sv
// Self-checking bench for the byte-coded register machine step block.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if and the block itself.
`timescale 1ns / 100ps

module tb_byte_coded_register_cpu_step;

  localparam logic       OP_WRITE   = 1'b0;
  localparam logic       OP_EXEC    = 1'b1;
  localparam logic [7:0] OPC_UNDEF  = 8'hFF;
  localparam int         MEM_SIZE   = 65536;
  localparam longint     CYCLE_CAP  = 6000000;
  localparam int         DRAIN_WAIT = 80;

  typedef struct packed {
    logic [7:0]  opc;
    logic [5:0]  cost;
    logic [15:0] pc;
    logic        w1;
    logic [7:0]  i1;
    logic [31:0] v1;
    logic        w2;
    logic [7:0]  i2;
    logic [31:0] v2;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcr_req_if req ();
  bcr_rsp_if rsp ();

  byte_coded_register_cpu_step #(.MEM_BYTES(MEM_SIZE)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow machine state, advanced as each request is accepted.
  logic [31:0] shadow_regs [256];
  logic [7:0]  shadow_mem  [MEM_SIZE];
  logic [15:0] shadow_pc;

  step_result_t pending_results [$];
  int           fail_count = 0;
  longint       cycle_count = 0;
  bit           gaps_on = 1'b1;
  int           burst_left = 0;
  int           hold_cycles = 0;   // receiver hold-off requested by a test

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = shadow_mem[shadow_pc];
    shadow_pc = shadow_pc + 16'd1;
    return b;
  endfunction

  // Every load and store byte address is formed in 32 bits, then reduced to the memory size.
  function automatic logic [7:0] mem_rd(input logic [31:0] addr);
    return shadow_mem[addr[15:0]];
  endfunction

  function automatic void mem_wr(input logic [31:0] addr, input logic [7:0] v);
    shadow_mem[addr[15:0]] = v;
  endfunction

  function automatic step_result_t machine_step(input logic op, input logic [15:0] addr,
                                                input logic [7:0] data);
    step_result_t r;
    logic [7:0]  ra, rb, rc, rd;
    logic [31:0] t, x;
    logic [63:0] p;
    r = '0;
    if (op == OP_WRITE) begin
      shadow_mem[addr] = data;
    end else begin
      r.opc = fetch_byte();
      case (r.opc)
        bcr_pkg::OPC_LDI: begin
          ra = fetch_byte();
          x[7:0] = fetch_byte();
          x[15:8] = fetch_byte();
          x[23:16] = fetch_byte();
          x[31:24] = fetch_byte();
          r.w1 = 1'b1; r.i1 = ra; r.v1 = x; r.cost = 6'd6;
        end
        bcr_pkg::OPC_MOV: begin
          rb = fetch_byte(); ra = fetch_byte();
          r.w1 = 1'b1; r.i1 = ra; r.v1 = shadow_regs[rb]; r.cost = 6'd3;
        end
        bcr_pkg::OPC_LDB: begin
          rb = fetch_byte(); ra = fetch_byte();
          r.w1 = 1'b1; r.i1 = ra; r.v1 = {24'd0, mem_rd(shadow_regs[rb])}; r.cost = 6'd5;
        end
        bcr_pkg::OPC_LDH: begin
          rb = fetch_byte(); ra = fetch_byte();
          t = shadow_regs[rb];
          r.w1 = 1'b1; r.i1 = ra; r.cost = 6'd6;
          r.v1 = {16'd0, mem_rd(t + 32'd1), mem_rd(t)};
        end
        bcr_pkg::OPC_LDW: begin
          rb = fetch_byte(); ra = fetch_byte();
          t = shadow_regs[rb];
          r.w1 = 1'b1; r.i1 = ra; r.cost = 6'd8;
          r.v1 = {mem_rd(t + 32'd3), mem_rd(t + 32'd2), mem_rd(t + 32'd1), mem_rd(t)};
        end
        bcr_pkg::OPC_STB: begin
          rb = fetch_byte(); ra = fetch_byte();
          mem_wr(shadow_regs[ra], shadow_regs[rb][7:0]);
          r.cost = 6'd5;
        end
        bcr_pkg::OPC_STH: begin
          rb = fetch_byte(); ra = fetch_byte();
          t = shadow_regs[ra]; x = shadow_regs[rb];
          mem_wr(t, x[7:0]);
          mem_wr(t + 32'd1, x[15:8]);
          r.cost = 6'd6;
        end
        bcr_pkg::OPC_STW: begin
          rb = fetch_byte(); ra = fetch_byte();
          t = shadow_regs[ra]; x = shadow_regs[rb];
          mem_wr(t, x[7:0]);
          mem_wr(t + 32'd1, x[15:8]);
          mem_wr(t + 32'd2, x[23:16]);
          mem_wr(t + 32'd3, x[31:24]);
          r.cost = 6'd8;
        end
        bcr_pkg::OPC_MUL: begin
          rb = fetch_byte(); rc = fetch_byte(); ra = fetch_byte(); rd = fetch_byte();
          p = {32'd0, shadow_regs[ra]} * {32'd0, shadow_regs[rb]};
          r.w1 = 1'b1; r.i1 = rc; r.v1 = p[31:0];
          r.w2 = 1'b1; r.i2 = rd; r.v2 = p[63:32];
          r.cost = 6'd5;
        end
        bcr_pkg::OPC_DIV: begin
          rb = fetch_byte(); rc = fetch_byte(); ra = fetch_byte(); rd = fetch_byte();
          x = shadow_regs[ra]; t = shadow_regs[rb];
          r.w1 = 1'b1; r.i1 = rc; r.w2 = 1'b1; r.i2 = rd;
          // divide by zero: all-ones quotient, dividend as remainder
          if (t == 32'd0) begin
            r.v1 = 32'hFFFF_FFFF; r.v2 = x;
          end else begin
            r.v1 = x / t; r.v2 = x % t;
          end
          r.cost = 6'd38;
        end
        bcr_pkg::OPC_LDS: begin
          ra = fetch_byte(); x[7:0] = fetch_byte();
          r.w1 = 1'b1; r.i1 = ra; r.v1 = {{24{x[7]}}, x[7:0]}; r.cost = 6'd3;
        end
        default: r.cost = 6'd1;
      endcase
      if (r.w1) shadow_regs[r.i1] = r.v1;
      if (r.w2) shadow_regs[r.i2] = r.v2;  // second write wins on equal indices
    end
    r.pc = shadow_pc;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Request driver: drive on the falling edge, accept on the rising edge
  // ------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [15:0] addr, input logic [7:0] data);
    req.op = op;
    req.load_addr = addr;
    req.load_data = data;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(machine_step(op, addr, data));
    @(negedge clk);
    req.valid = 1'b0;
    // Bursts of random length separated by random gaps.
    if (gaps_on) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 9)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Copy an instruction into memory at the current pc, then execute it.
  task automatic run_code(input logic [7:0] code[$]);
    logic [15:0] base;
    base = shadow_pc;
    foreach (code[i]) send_request(OP_WRITE, base + 16'(i), code[i]);
    send_request(OP_EXEC, 16'd0, 8'd0);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // ------------------------------------------------------------------
  // Result receiver: stall pattern of its own plus test-driven hold-off
  // ------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    rsp.ready = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(40, 200);
      end
      span--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready = 1'b0;
      end else if (mode == 0) begin
        rsp.ready = 1'b1;
      end else if (mode == 1) begin
        rsp.ready = 1'($urandom_range(0, 1));
      end else begin
        rsp.ready = ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    step_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("executed_opcode", 32'(e.opc), 32'(rsp.executed_opcode));
        check_field("cycle_cost", 32'(e.cost), 32'(rsp.cycle_cost));
        check_field("pc_after", 32'(e.pc), 32'(rsp.pc_after));
        check_field("first_write_valid", 32'(e.w1), 32'(rsp.first_write_valid));
        check_field("first_write_index", 32'(e.i1), 32'(rsp.first_write_index));
        check_field("first_write_value", e.v1, rsp.first_write_value);
        check_field("second_write_valid", 32'(e.w2), 32'(rsp.second_write_valid));
        check_field("second_write_index", 32'(e.i2), 32'(rsp.second_write_index));
        check_field("second_write_value", e.v2, rsp.second_write_value);
      end
    end
  end

  // Watchdog; allows for the memory clearing pass after reset.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL byte_coded_register_cpu_step");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [7:0] pick_reg();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 1023));
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(16'hFFF0, 32'h0001_0008));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b <= bcr_pkg::OPC_DIV || b == bcr_pkg::OPC_LDS);
    return b;
  endfunction

  task automatic ldi(input logic [7:0] a, input logic [31:0] v);
    run_code('{bcr_pkg::OPC_LDI, a, v[7:0], v[15:8], v[23:16], v[31:24]});
  endtask

  // Build one well-formed instruction with random operands, or a lone undefined opcode.
  task automatic run_random_instr();
    logic [7:0]  opc;
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: opc = bcr_pkg::OPC_LDI;
      1: opc = bcr_pkg::OPC_MOV;
      2: opc = bcr_pkg::OPC_LDB;
      3: opc = bcr_pkg::OPC_LDH;
      4: opc = bcr_pkg::OPC_LDW;
      5: opc = bcr_pkg::OPC_STB;
      6: opc = bcr_pkg::OPC_STH;
      7: opc = bcr_pkg::OPC_STW;
      8: opc = bcr_pkg::OPC_MUL;
      9: opc = bcr_pkg::OPC_DIV;
      10: opc = bcr_pkg::OPC_LDS;
      default: opc = pick_unknown();
    endcase
    case (opc)
      bcr_pkg::OPC_LDI: ldi(pick_reg(), pick_value());
      bcr_pkg::OPC_MUL, bcr_pkg::OPC_DIV:
        run_code('{opc, pick_reg(), pick_reg(), pick_reg(), pick_reg()});
      bcr_pkg::OPC_LDS: run_code('{opc, pick_reg(), 8'($urandom_range(0, 255))});
      bcr_pkg::OPC_MOV, bcr_pkg::OPC_LDB, bcr_pkg::OPC_LDH, bcr_pkg::OPC_LDW,
      bcr_pkg::OPC_STB, bcr_pkg::OPC_STH, bcr_pkg::OPC_STW:
        run_code('{opc, pick_reg(), pick_reg()});
      default: run_code('{opc});
    endcase
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    // byte writes at both ends of memory
    send_request(OP_WRITE, 16'hFFFF, 8'hFF);
    send_request(OP_WRITE, 16'h0000, 8'h00);
    ldi(8'd1, 32'hFFFF_FFFF);
    ldi(8'd2, 32'h0000_0000);
    ldi(8'd3, 32'h1234_5678);
    run_code('{bcr_pkg::OPC_LDS, 8'd4, 8'h80});        // negative byte
    run_code('{bcr_pkg::OPC_LDS, 8'd5, 8'h7F});        // positive byte
    run_code('{bcr_pkg::OPC_MOV, 8'd3, 8'd255});
    // word store at the top address wraps to the bottom of memory
    run_code('{bcr_pkg::OPC_STW, 8'd3, 8'd1});
    run_code('{bcr_pkg::OPC_LDW, 8'd1, 8'd6});
    run_code('{bcr_pkg::OPC_LDH, 8'd1, 8'd7});
    run_code('{bcr_pkg::OPC_LDB, 8'd1, 8'd8});
    run_code('{bcr_pkg::OPC_STH, 8'd4, 8'd1});
    run_code('{bcr_pkg::OPC_STB, 8'd5, 8'd2});
    run_code('{bcr_pkg::OPC_MUL, 8'd1, 8'd10, 8'd1, 8'd11});   // largest product
    run_code('{bcr_pkg::OPC_DIV, 8'd2, 8'd12, 8'd3, 8'd13});   // divide by zero
    run_code('{bcr_pkg::OPC_DIV, 8'd5, 8'd14, 8'd3, 8'd15});
    run_code('{bcr_pkg::OPC_DIV, 8'd5, 8'd16, 8'd3, 8'd16});   // equal destinations
    run_code('{bcr_pkg::OPC_MUL, 8'd3, 8'd17, 8'd4, 8'd17});
    run_code('{OPC_UNDEF});
    run_code('{8'h0A});
    run_code('{8'h1D});
    wait_drained();
  endtask

  task automatic test_random_programs();
    repeat (70) begin
      if ($urandom_range(0, 9) < 8) begin
        run_random_instr();
      end else if ($urandom_range(0, 1) == 0) begin
        // noise: a stray byte anywhere in memory
        send_request(OP_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else begin
        // broken sequence: execute whatever lies at pc
        send_request(OP_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    // hold the result side long enough that the block stops taking requests
    hold_cycles = 400;
    repeat (8) run_random_instr();
    wait_drained();
    // pause until everything is back, then carry on
    repeat (6) run_random_instr();
    wait_drained();
  endtask

  initial begin
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_pc = '0;
    req.valid = 1'b0;
    req.op = OP_WRITE;
    req.load_addr = '0;
    req.load_data = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_programs();
    test_backpressure();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS byte_coded_register_cpu_step");
    end else begin
      $display("FAIL byte_coded_register_cpu_step");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bcr_pkg.sv
hw/rtl/bcr_req_if.sv
hw/rtl/bcr_rsp_if.sv
hw/rtl/bcr_alu.sv
hw/rtl/byte_coded_register_cpu_step.sv
bench/tb_byte_coded_register_cpu_step.sv
